### rtl/vrot_pkg.sv
// Shared types, register indexes and rounding helper for the vertex rotator.
`default_nettype none
package vrot_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_VEL_X = 2'd0;
  localparam logic [1:0] REG_VEL_Y = 2'd1;
  localparam logic [1:0] REG_VEL_Z = 2'd2;

  localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

  // Derived rotation, Q2.30; the y component of the axis is always zero
  typedef struct packed {
    logic               vel_short;
    logic signed [31:0] qa;
    logic signed [31:0] qc;
    logic signed [31:0] qw;
  } vrot_quat_t;

  // Shift right by 30, rounding half away from zero
  function automatic logic signed [41:0] rnd30(input logic signed [71:0] x);
    logic signed [72:0] xe;
    logic        [72:0] m;
    logic        [72:0] q;
    logic signed [41:0] qs;
    xe = {x[71], x};
    m  = xe[72] ? 73'(-xe) : 73'(xe);
    q  = (m + 73'(1 << 29)) >> 30;
    qs = 42'(q);
    return xe[72] ? -qs : qs;
  endfunction

endpackage
`default_nettype wire

### rtl/vrot_derive.sv
// Setup sequencer: normalizes the velocity and forms the shortest-arc quaternion.
`default_nettype none
module vrot_derive (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               go,
  input  wire logic signed [31:0] vel_x,
  input  wire logic signed [31:0] vel_y,
  input  wire logic signed [31:0] vel_z,
  output logic                    busy,
  output vrot_pkg::vrot_quat_t    quat
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SQR, ST_ROOT, ST_DLOAD, ST_DIVI, ST_XFER
  } state_t;

  state_t               st_r;
  logic                 phase_r;
  logic [1:0]           k_r;
  logic [5:0]           cnt_r;
  logic [63:0]          acc_r;
  logic [63:0]          x_r;
  logic [63:0]          root_r;
  logic [63:0]          bit_r;
  logic [31:0]          den_r;
  logic [63:0]          num_r;
  logic [31:0]          rem_r;
  logic [31:0]          quo_r;
  logic signed [32:0]   op_r [3];
  logic signed [31:0]   res_r [3];
  vrot_pkg::vrot_quat_t quat_r;

  // square of the current operand magnitude
  logic [31:0] op_mag;
  logic [63:0] sq;
  always_comb begin
    op_mag = op_r[k_r][32] ? 32'(-op_r[k_r]) : 32'(op_r[k_r]);
    sq     = 64'(op_mag) * 64'(op_mag);
  end

  // one step of the bitwise square root
  logic [64:0] rt_sum;
  logic [63:0] x_nxt;
  logic [63:0] root_nxt;
  always_comb begin
    rt_sum = {1'b0, root_r} + {1'b0, bit_r};
    if ({1'b0, x_r} >= rt_sum) begin
      x_nxt    = x_r - rt_sum[63:0];
      root_nxt = (root_r >> 1) + bit_r;
    end else begin
      x_nxt    = x_r;
      root_nxt = root_r >> 1;
    end
  end

  // one step of restoring division
  logic [32:0] rem_s;
  logic [31:0] rem_nxt;
  logic        qbit;
  logic [31:0] quo_nxt;
  always_comb begin
    rem_s = {rem_r, num_r[63]};
    qbit  = rem_s >= {1'b0, den_r};
    rem_nxt = qbit ? 32'(rem_s - {1'b0, den_r}) : rem_s[31:0];
    quo_nxt = {quo_r[30:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r           <= ST_IDLE;
      phase_r        <= 1'b0;
      k_r            <= '0;
      cnt_r          <= '0;
      quat_r.vel_short <= 1'b1;
      quat_r.qa      <= '0;
      quat_r.qc      <= '0;
      quat_r.qw      <= '0;
    end else begin
      case (st_r)
        ST_IDLE: begin
          if (go) begin
            if (vel_x == '0 && vel_y == '0 && vel_z == '0) begin
              quat_r.vel_short <= 1'b1;
              quat_r.qa <= '0;
              quat_r.qc <= '0;
              quat_r.qw <= '0;
            end else begin
              op_r[0] <= 33'(vel_x);
              op_r[1] <= 33'(vel_y);
              op_r[2] <= 33'(vel_z);
              phase_r <= 1'b0;
              k_r     <= '0;
              acc_r   <= '0;
              st_r    <= ST_SQR;
            end
          end
        end
        ST_SQR: begin
          acc_r <= acc_r + sq;
          if (k_r == 2'd2) begin
            x_r    <= acc_r + sq;
            root_r <= '0;
            bit_r  <= 64'd1 << 62;
            cnt_r  <= '0;
            st_r   <= ST_ROOT;
          end else begin
            k_r <= k_r + 2'd1;
          end
        end
        ST_ROOT: begin
          x_r    <= x_nxt;
          root_r <= root_nxt;
          bit_r  <= bit_r >> 2;
          cnt_r  <= cnt_r + 6'd1;
          if (cnt_r == 6'd31) begin
            den_r <= root_nxt[31:0];
            k_r   <= '0;
            if (phase_r && root_nxt == '0) begin
              // axis opposite to +Y: half turn about X
              quat_r.vel_short <= 1'b0;
              quat_r.qa <= vrot_pkg::ONE_Q30;
              quat_r.qc <= '0;
              quat_r.qw <= '0;
              st_r      <= ST_IDLE;
            end else begin
              st_r <= ST_DLOAD;
            end
          end
        end
        ST_DLOAD: begin
          num_r <= (64'(op_mag) << 30) + 64'(den_r >> 1);
          rem_r <= '0;
          quo_r <= '0;
          cnt_r <= '0;
          st_r  <= ST_DIVI;
        end
        ST_DIVI: begin
          num_r <= num_r << 1;
          rem_r <= rem_nxt;
          quo_r <= quo_nxt;
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd63) begin
            res_r[k_r] <= op_r[k_r][32] ? -$signed(quo_nxt) : $signed(quo_nxt);
            if (k_r == 2'd2) begin
              st_r <= ST_XFER;
            end else begin
              k_r  <= k_r + 2'd1;
              st_r <= ST_DLOAD;
            end
          end
        end
        ST_XFER: begin
          if (!phase_r) begin
            // q = (dz, 0, -dx), w = 1 + dy; ordered (qx, w, qz)
            op_r[0] <= 33'(res_r[2]);
            op_r[1] <= 33'(vrot_pkg::ONE_Q30) + 33'(res_r[1]);
            op_r[2] <= -33'(res_r[0]);
            phase_r <= 1'b1;
            k_r     <= '0;
            acc_r   <= '0;
            st_r    <= ST_SQR;
          end else begin
            quat_r.vel_short <= 1'b0;
            quat_r.qa <= res_r[0];
            quat_r.qw <= res_r[1];
            quat_r.qc <= res_r[2];
            st_r      <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign busy = (st_r != ST_IDLE);
  assign quat = quat_r;

endmodule
`default_nettype wire

### rtl/vrot_lane.sv
// Rotation pipeline for one vector: p + 2*q x (q x p + w*p).
`default_nettype none
module vrot_lane #(
  parameter int W = 32
) (
  input  wire logic                  clk,
  input  wire logic signed [31:0]    qa,
  input  wire logic signed [31:0]    qc,
  input  wire logic signed [31:0]    qw,
  input  wire logic signed [W-1:0]   p_x,
  input  wire logic signed [W-1:0]   p_y,
  input  wire logic signed [W-1:0]   p_z,
  output logic signed [W-1:0]        r_x,
  output logic signed [W-1:0]        r_y,
  output logic signed [W-1:0]        r_z
);

  localparam logic signed [44:0] HI = (45'sd1 <<< (W - 1)) - 45'sd1;
  localparam logic signed [44:0] LO = -HI - 45'sd1;

  logic signed [W-1:0] p0_r [3];
  logic signed [W-1:0] p1_r [3];
  logic signed [W-1:0] p2_r [3];
  logic signed [W-1:0] p3_r [3];

  // stage 1 products (axis y term is zero)
  logic signed [63:0] cp1_r, wp0_r, cp0_r, ap2_r, wp1_r, ap1_r, wp2_r;
  // stage 2: t = q x p + w*p
  logic signed [41:0] t0_r, t1_r, t2_r;
  // stage 3 products of q x t
  logic signed [71:0] ct1_r, ct0_r, at2_r, at1_r;

  always_ff @(posedge clk) begin
    p0_r[0] <= p_x;
    p0_r[1] <= p_y;
    p0_r[2] <= p_z;
    p1_r    <= p0_r;
    p2_r    <= p1_r;
    p3_r    <= p2_r;

    cp1_r <= 64'(qc * p0_r[1]);
    wp0_r <= 64'(qw * p0_r[0]);
    cp0_r <= 64'(qc * p0_r[0]);
    ap2_r <= 64'(qa * p0_r[2]);
    wp1_r <= 64'(qw * p0_r[1]);
    ap1_r <= 64'(qa * p0_r[1]);
    wp2_r <= 64'(qw * p0_r[2]);

    t0_r <= vrot_pkg::rnd30(72'(wp0_r) - 72'(cp1_r));
    t1_r <= vrot_pkg::rnd30(72'(cp0_r) - 72'(ap2_r) + 72'(wp1_r));
    t2_r <= vrot_pkg::rnd30(72'(ap1_r) + 72'(wp2_r));

    ct1_r <= 72'(qc * t1_r);
    ct0_r <= 72'(qc * t0_r);
    at2_r <= 72'(qa * t2_r);
    at1_r <= 72'(qa * t1_r);
  end

  logic signed [42:0] c_v [3];
  logic signed [44:0] s_v [3];
  logic signed [W-1:0] r_nxt [3];
  always_comb begin
    c_v[0] = -43'(vrot_pkg::rnd30(ct1_r));
    c_v[1] = 43'(vrot_pkg::rnd30(ct0_r)) - 43'(vrot_pkg::rnd30(at2_r));
    c_v[2] = 43'(vrot_pkg::rnd30(at1_r));
    for (int i = 0; i < 3; i++) begin
      s_v[i] = 45'(p3_r[i]) + 45'(c_v[i] <<< 1);
      if (s_v[i] > HI)      r_nxt[i] = W'(HI);
      else if (s_v[i] < LO) r_nxt[i] = W'(LO);
      else                  r_nxt[i] = W'(s_v[i]);
    end
  end

  always_ff @(posedge clk) begin
    r_x <= r_nxt[0];
    r_y <= r_nxt[1];
    r_z <= r_nxt[2];
  end

endmodule
`default_nettype wire

### rtl/velocity_align_vertex_rotator.sv
// Top level of the velocity-aligned vertex rotator.
//
// Usage:
//  - Configuration: write vel_x/vel_y/vel_z (Q16.16) through cfg_valid/cfg_ready
//    with cfg_index 0..2; other indexes are dropped. Each write to a velocity
//    register launches the setup sequencer, which holds busy high (and
//    cfg_ready low) while it works: two passes, the second ending after its
//    square root when the velocity points straight down, none for zero
//    velocity. Nonzero velocity is required for a valid rotation.
//  - Input: a vertex (position Q16.16, normal Q2.14) transfers on any
//    edge with start high and busy low; one vertex per cycle while not busy.
//  - Output: out_valid is high for one cycle for each accepted vertex, when
//    its valid bit leaves vld_r beside the lane stages. Results come in
//    order; the receiver cannot stall, so there is no backpressure path.
//  - Each lane is a pipeline of input register, product stage,
//    cross-product sum, second product stage and saturating output stage.
//  - With zero velocity every result is zero with out_invalid set.
//  - Reset (synchronous, rst_n low) clears the velocity, marks it short and
//    empties the pipeline; no setup pass is needed after reset.
`default_nettype none
module velocity_align_vertex_rotator (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // vertex input
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_y,
  input  wire logic signed [31:0] in_pos_z,
  input  wire logic signed [15:0] in_nrm_x,
  input  wire logic signed [15:0] in_nrm_y,
  input  wire logic signed [15:0] in_nrm_z,
  // result
  output logic                    out_valid,
  output logic signed [31:0]      out_pos_x,
  output logic signed [31:0]      out_pos_y,
  output logic signed [31:0]      out_pos_z,
  output logic signed [15:0]      out_nrm_x,
  output logic signed [15:0]      out_nrm_y,
  output logic signed [15:0]      out_nrm_z,
  output logic                    out_invalid,
  // configuration
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  logic signed [31:0]   vel_x_r, vel_y_r, vel_z_r;
  logic                 go_r;
  logic                 der_busy;
  vrot_pkg::vrot_quat_t quat;
  logic [4:0]           vld_r;   // valid bits alongside lane stages

  logic cfg_xfer;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign busy      = go_r || der_busy;
  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vel_x_r <= '0;
      vel_y_r <= '0;
      vel_z_r <= '0;
      go_r    <= 1'b0;
      vld_r   <= '0;
    end else begin
      go_r <= 1'b0;
      if (cfg_xfer) begin
        case (cfg_index)
          vrot_pkg::REG_VEL_X: begin vel_x_r <= cfg_data; go_r <= 1'b1; end
          vrot_pkg::REG_VEL_Y: begin vel_y_r <= cfg_data; go_r <= 1'b1; end
          vrot_pkg::REG_VEL_Z: begin vel_z_r <= cfg_data; go_r <= 1'b1; end
          default: ;
        endcase
      end
      vld_r <= {vld_r[3:0], start && !busy};
    end
  end

  vrot_derive u_derive (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go_r),
    .vel_x (vel_x_r),
    .vel_y (vel_y_r),
    .vel_z (vel_z_r),
    .busy  (der_busy),
    .quat  (quat)
  );

  logic signed [31:0] rp_x, rp_y, rp_z;
  logic signed [15:0] rn_x, rn_y, rn_z;

  vrot_lane #(.W(32)) u_pos (
    .clk (clk), .qa (quat.qa), .qc (quat.qc), .qw (quat.qw),
    .p_x (in_pos_x), .p_y (in_pos_y), .p_z (in_pos_z),
    .r_x (rp_x), .r_y (rp_y), .r_z (rp_z)
  );

  vrot_lane #(.W(16)) u_nrm (
    .clk (clk), .qa (quat.qa), .qc (quat.qc), .qw (quat.qw),
    .p_x (in_nrm_x), .p_y (in_nrm_y), .p_z (in_nrm_z),
    .r_x (rn_x), .r_y (rn_y), .r_z (rn_z)
  );

  // short velocity zeroes results; user, not block, holds it while items flow
  assign out_valid   = vld_r[4];
  assign out_invalid = quat.vel_short;
  assign out_pos_x   = quat.vel_short ? '0 : rp_x;
  assign out_pos_y   = quat.vel_short ? '0 : rp_y;
  assign out_pos_z   = quat.vel_short ? '0 : rp_z;
  assign out_nrm_x   = quat.vel_short ? '0 : rn_x;
  assign out_nrm_y   = quat.vel_short ? '0 : rn_y;
  assign out_nrm_z   = quat.vel_short ? '0 : rn_z;

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##4 out_valid)
    else $error("accepted vertex did not produce a result");
  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    quat.vel_short |-> (quat.qa == '0 && quat.qc == '0 && quat.qw == '0))
    else $error("short velocity with nonzero quaternion");
  a_scalar_pos: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> !quat.qw[31])
    else $error("negative quaternion scalar");
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_invalid) |-> (out_pos_x == '0 && out_nrm_z == '0))
    else $error("invalid result carries data");
`endif

endmodule
`default_nettype wire

### tb/sv/tb_velocity_align_vertex_rotator.sv
// Testbench for the velocity-aligned vertex rotator: directed table, then random vertices.
`timescale 1ns / 1ps
module tb_velocity_align_vertex_rotator;

  // index past the three velocity registers, write must be dropped
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int ITEMS_PER_GROUP = 25;
  localparam int GROUPS_PER_PHASE = 6;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic signed [31:0] px, py, pz;
    logic signed [15:0] nx, ny, nz;
  } vertex_t;

  typedef struct packed {
    logic signed [31:0] px, py, pz;
    logic signed [15:0] nx, ny, nz;
    logic               inv;
  } rot_res_t;

  typedef struct {
    bit          is_cfg;
    logic [1:0]  idx;
    logic [31:0] data;
    vertex_t     vtx;
    bit          typed;     // expected result typed in below
    rot_res_t    res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic signed [15:0] in_nrm_x = '0, in_nrm_y = '0, in_nrm_z = '0;
  logic out_valid;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
  logic signed [15:0] out_nrm_x, out_nrm_y, out_nrm_z;
  logic out_invalid;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  velocity_align_vertex_rotator dut (
    .clk, .rst_n, .start, .busy,
    .in_pos_x, .in_pos_y, .in_pos_z, .in_nrm_x, .in_nrm_y, .in_nrm_z,
    .out_valid, .out_pos_x, .out_pos_y, .out_pos_z,
    .out_nrm_x, .out_nrm_y, .out_nrm_z, .out_invalid,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow of the rotation: velocity registers and the quaternion they give
  wide_t    vel_reg [3];
  wide_t    rot_a, rot_c, rot_w;   // Q2.30, y part of the axis is always zero
  bit       vel_zero;
  rot_res_t rotated_q [$];         // results still due from the block
  int       mismatches = 0;
  int       sender_idle_pct = 0;

  function automatic wide_t mag_w(wide_t x);
    return x < 0 ? -x : x;
  endfunction

  function automatic wide_t isqrt_w(wide_t x);
    wide_t r, b;
    r = 0;
    b = wide_t'(1) << 124;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // x / den to Q2.30, magnitude rounded half up
  function automatic wide_t div_q30(wide_t x, wide_t den);
    wide_t q;
    q = ((mag_w(x) << 30) + den / 2) / den;
    return x < 0 ? -q : q;
  endfunction

  // >> 30 with rounding half away from zero
  function automatic wide_t rnd_q30(wide_t x);
    wide_t q;
    q = (mag_w(x) + (wide_t'(1) << 29)) >> 30;
    return x < 0 ? -q : q;
  endfunction

  function automatic wide_t clamp_w(wide_t x, int bits);
    wide_t hi, lo;
    hi = (wide_t'(1) << (bits - 1)) - 1;
    lo = -hi - 1;
    return x > hi ? hi : (x < lo ? lo : x);
  endfunction

  // Recompute the quaternion after any velocity change
  task automatic derive_rotation();
    wide_t n, m, dx, dy, dz, qx, qz, w;
    if (vel_reg[0] == 0 && vel_reg[1] == 0 && vel_reg[2] == 0) begin
      vel_zero = 1'b1;
      rot_a = 0; rot_c = 0; rot_w = 0;
      return;
    end
    vel_zero = 1'b0;
    n = isqrt_w(vel_reg[0] * vel_reg[0] + vel_reg[1] * vel_reg[1] + vel_reg[2] * vel_reg[2]);
    dx = div_q30(vel_reg[0], n);
    dy = div_q30(vel_reg[1], n);
    dz = div_q30(vel_reg[2], n);
    qx = dz;
    qz = -dx;
    w = (wide_t'(1) << 30) + dy;
    m = isqrt_w(qx * qx + qz * qz + w * w);
    if (m == 0) begin
      // velocity straight down: half turn about X
      rot_a = wide_t'(1) << 30; rot_c = 0; rot_w = 0;
    end else begin
      rot_a = div_q30(qx, m);
      rot_c = div_q30(qz, m);
      rot_w = div_q30(w, m);
    end
  endtask

  // p + 2 * q x (q x p + w p), saturated to bits
  function automatic void rotate_vec(input wide_t p [3], input int bits, output wide_t r [3]);
    wide_t t0, t1, t2, c0, c1, c2;
    t0 = rnd_q30(-rot_c * p[1] + rot_w * p[0]);
    t1 = rnd_q30(rot_c * p[0] - rot_a * p[2] + rot_w * p[1]);
    t2 = rnd_q30(rot_a * p[1] + rot_w * p[2]);
    c0 = -rnd_q30(rot_c * t1);
    c1 = rnd_q30(rot_c * t0) - rnd_q30(rot_a * t2);
    c2 = rnd_q30(rot_a * t1);
    r[0] = clamp_w(p[0] + 2 * c0, bits);
    r[1] = clamp_w(p[1] + 2 * c1, bits);
    r[2] = clamp_w(p[2] + 2 * c2, bits);
  endfunction

  function automatic rot_res_t rotate_vertex(vertex_t v);
    wide_t p [3], nv [3], rp [3], rn [3];
    rot_res_t res;
    res = '0;
    if (vel_zero) begin
      res.inv = 1'b1;
      return res;
    end
    p = '{wide_t'(v.px), wide_t'(v.py), wide_t'(v.pz)};
    nv = '{wide_t'(v.nx), wide_t'(v.ny), wide_t'(v.nz)};
    rotate_vec(p, 32, rp);
    rotate_vec(nv, 16, rn);
    res.px = rp[0][31:0]; res.py = rp[1][31:0]; res.pz = rp[2][31:0];
    res.nx = rn[0][15:0]; res.ny = rn[1][15:0]; res.nz = rn[2][15:0];
    return res;
  endfunction

  // Present one vertex and hold it until the transfer; busy is read before the edge
  task automatic send_vertex(vertex_t v, bit typed, rot_res_t res);
    start    <= 1'b1;
    in_pos_x <= v.px; in_pos_y <= v.py; in_pos_z <= v.pz;
    in_nrm_x <= v.nx; in_nrm_y <= v.ny; in_nrm_z <= v.nz;
    do @(posedge clk); while (busy);
    rotated_q = {rotated_q, (typed ? res : rotate_vertex(v))};
    // random sender gaps between transfers
    if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
  endtask

  // Register write, only once every result is back
  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    start <= 1'b0;
    while (rotated_q.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx != REG_UNUSED) begin
      vel_reg[idx] = wide_t'($signed(data));
      derive_rotation();
    end
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(6))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'(signed'(20'($urandom)));
      4: return 32'(signed'(8'($urandom))) <<< 16;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_half();
    case ($urandom_range(5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h4000;
      3: return 16'hc000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic stim_row_t cfg_row(logic [1:0] idx, logic [31:0] data);
    stim_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1; row.idx = idx; row.data = data;
    return row;
  endfunction

  function automatic stim_row_t vtx_row(vertex_t v, bit typed, rot_res_t res);
    stim_row_t row;
    row = '{default: '0};
    row.vtx = v; row.typed = typed; row.res = res;
    return row;
  endfunction

  // Results: strobed for one cycle, compared in order
  always @(posedge clk) begin
    rot_res_t got, want;
    if (rst_n && out_valid) begin
      got = '{out_pos_x, out_pos_y, out_pos_z, out_nrm_x, out_nrm_y, out_nrm_z, out_invalid};
      if (rotated_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer %h", got);
      end else begin
        want = rotated_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch pos %h %h %h nrm %h %h %h inv %b, got %h %h %h nrm %h %h %h inv %b",
                     want.px, want.py, want.pz, want.nx, want.ny, want.nz, want.inv,
                     got.px, got.py, got.pz, got.nx, got.ny, got.nz, got.inv);
        end
      end
    end
  end

  initial begin
    stim_row_t tab [$];
    vertex_t vmax, vmin, vmix, vsmall, v;
    int idle_pct [4];
    vmax   = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 16'h7fff, 16'h7fff, 16'h7fff};
    vmin   = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h8000, 16'h8000, 16'h8000};
    vmix   = '{32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, 16'h7fff, 16'h8000, 16'h4000};
    vsmall = '{32'h0003_0000, 32'h0002_0000, 32'hfffe_0000, 16'h1000, 16'h2000, 16'he000};
    idle_pct = '{0, 53, 0, 23};
    vel_reg = '{0, 0, 0};
    derive_rotation();

    // zero velocity right after reset: everything zero, invalid set
    tab = {tab, vtx_row(vmix, 1, '{0, 0, 0, 0, 0, 0, 1'b1})};
    // straight up: identity rotation
    tab = {tab, cfg_row(vrot_pkg::REG_VEL_Y, 32'h0001_0000)};
    tab = {tab, vtx_row(vmax, 1, {vmax, 1'b0})};
    tab = {tab, vtx_row(vmin, 1, {vmin, 1'b0})};
    tab = {tab, vtx_row(vmix, 1, {vmix, 1'b0})};
    // straight down: half turn about X, y and z negated with saturation
    tab = {tab, cfg_row(vrot_pkg::REG_VEL_Y, 32'hffff_0000)};
    tab = {tab, vtx_row(vmix, 1, '{32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_0000,
                                   16'h7fff, 16'h7fff, 16'hc000, 1'b0})};
    tab = {tab, vtx_row(vmin, 1, '{32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                                   16'h8000, 16'h7fff, 16'h7fff, 1'b0})};
    // write to an unused index leaves the rotation alone
    tab = {tab, cfg_row(REG_UNUSED, 32'h1234_5678)};
    tab = {tab, vtx_row(vsmall, 1, '{32'h0003_0000, 32'hfffe_0000, 32'h0002_0000,
                                     16'h1000, 16'he000, 16'h2000, 1'b0})};
    // register extremes, checked by the shadow model
    tab = {tab, cfg_row(vrot_pkg::REG_VEL_X, 32'h7fff_ffff)};
    tab = {tab, vtx_row(vmax, 0, '0)};
    tab = {tab, vtx_row(vmix, 0, '0)};
    tab = {tab, cfg_row(vrot_pkg::REG_VEL_Z, 32'h8000_0000)};
    tab = {tab, vtx_row(vsmall, 0, '0)};
    tab = {tab, cfg_row(vrot_pkg::REG_VEL_Y, 32'h8000_0000)};
    tab = {tab, vtx_row(vmin, 0, '0)};
    tab = {tab, vtx_row('0, 0, '0)};
    // back to zero velocity
    tab = {tab, cfg_row(vrot_pkg::REG_VEL_X, 32'h0)};
    tab = {tab, cfg_row(vrot_pkg::REG_VEL_Y, 32'h0)};
    tab = {tab, cfg_row(vrot_pkg::REG_VEL_Z, 32'h0)};
    tab = {tab, vtx_row(vmax, 1, '{0, 0, 0, 0, 0, 0, 1'b1})};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (tab[i]) begin
      if (tab[i].is_cfg) write_reg(tab[i].idx, tab[i].data);
      else send_vertex(tab[i].vtx, tab[i].typed, tab[i].res);
    end

    // Random part: phases of sender idling, register writes between groups
    foreach (idle_pct[ph]) begin
      for (int g = 0; g < GROUPS_PER_PHASE; g++) begin
        sender_idle_pct = 0;
        if ($urandom_range(9) == 0) begin
          // occasionally drop back to the zero velocity
          write_reg(vrot_pkg::REG_VEL_X, 32'h0);
          write_reg(vrot_pkg::REG_VEL_Y, 32'h0);
          write_reg(vrot_pkg::REG_VEL_Z, 32'h0);
        end else begin
          repeat ($urandom_range(1, 3))
            write_reg(2'($urandom_range(3)), pick_word());
        end
        sender_idle_pct = idle_pct[ph];
        for (int k = 0; k < ITEMS_PER_GROUP; k++) begin
          v = '{pick_word(), pick_word(), pick_word(), pick_half(), pick_half(), pick_half()};
          send_vertex(v, 0, '0);
        end
      end
    end
    start <= 1'b0;

    while (rotated_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && rotated_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
